FILE: hdl/obit_pkg.sv
// ----------------------------------------------------------------------------
// obit_pkg
// Shared types and constants of the occupancy bitmap interval table.
// ----------------------------------------------------------------------------
`default_nettype none

package obit_pkg;

   localparam int KIND_W     = 2;
   localparam int VERTEX_W   = 8;
   localparam int TIME_W     = 6;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 9;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 9;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_LAST_TIME    = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_VERTEX_COUNT = 1'b1;

   localparam logic [TIME_W-1:0]  LAST_TIME_RESET    = 6'd63;
   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 9'd256;

   typedef enum logic [KIND_W-1:0] {
      KIND_MARK     = 2'd0,
      KIND_COMPLETE = 2'd1,
      KIND_CHECK    = 2'd2,
      KIND_EXTRACT  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 3'd0,
      STATUS_BAD_VERTEX  = 3'd1,
      STATUS_BAD_TIME    = 3'd2,
      STATUS_SRC_UNSAFE  = 3'd3,
      STATUS_NO_INTERVAL = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MARK_WR,
      ST_CPL,
      ST_CHK_SRC,
      ST_CHK_DST,
      ST_EXT_LOAD,
      ST_EXT_SCAN
   } state_type;

   typedef struct packed {
      status_type        status;
      logic              conflict;
      logic [TIME_W-1:0] istart;
      logic [TIME_W-1:0] iend;
      logic              open_end;
      logic              last;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/obit_ram.sv
// ----------------------------------------------------------------------------
// obit_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module obit_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/occupancy_bitmap_interval_table_core.sv
// ----------------------------------------------------------------------------
// occupancy_bitmap_interval_table_core
// Per-vertex safe-time bitmaps with mark, complete, check and run extraction.
// ----------------------------------------------------------------------------
// Usage
//   An item is taken when start is high and busy is low. Results come out as
//   words on the rsp_ ports, each flagged by rsp_valid for a single cycle;
//   rsp_last marks the final word of the item. The receiver cannot stall.
//   Configuration writes (csr_we, csr_addr, csr_wdata) are registered directly
//   and must be made while the block is idle; the block itself does not enforce this.
// Steps per item
//   range errors           : result registered at accept, busy stays low
//   mark                   : row read, then read-modify-write
//   check                  : source read, then target read if the source is safe
//                            (one map read port, source and target in turn)
//   extract                : row read and load, then one bit a cycle
//                            through the shift unit, up to bit last_time
//   complete               : one row a cycle through the read-modify-write
//                            pipeline, over the effective vertex count
// Reset
//   A synchronous reset starts a clearing pass that zeroes both bitmap
//   memories, one row a cycle, with busy high. Configuration writes are
//   taken during the pass.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_bitmap_interval_table_core #(
   parameter int VERTICES  = 256,
   parameter int TIMESTEPS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [obit_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [obit_pkg::VERTEX_W-1:0]   req_vertex,
   input  wire logic [obit_pkg::VERTEX_W-1:0]   req_target_vertex,
   input  wire logic [obit_pkg::TIME_W-1:0]     req_time_req,
   input  wire logic                            req_also_list,
   output logic                                 rsp_valid,
   output logic [obit_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_conflict,
   output logic [obit_pkg::TIME_W-1:0]          rsp_interval_start,
   output logic [obit_pkg::TIME_W-1:0]          rsp_interval_end,
   output logic                                 rsp_open_end,
   output logic                                 rsp_last,
   input  wire logic                            csr_we,
   input  wire logic [obit_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [obit_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW  = $clog2(VERTICES);
   localparam int TIB = $clog2(TIMESTEPS);
   localparam int TW  = obit_pkg::TIME_W;
   localparam int CW  = obit_pkg::COUNT_W;

   // state and registers
   obit_pkg::state_type state_ff, state_in;
   logic [TW-1:0]              last_time_ff;
   logic [CW-1:0]              vertex_count_ff;
   logic [AW-1:0]              clr_idx_ff, clr_idx_in;
   logic [obit_pkg::VERTEX_W-1:0] v_ff, v_in, tv_ff, tv_in;
   logic [TW-1:0]              t_ff, t_in;
   logic                       also_ff, also_in;
   logic [AW:0]                rd_idx_ff, rd_idx_in;
   logic                       pend_vld_ff, pend_vld_in;
   logic [AW-1:0]              pend_idx_ff, pend_idx_in;
   logic [TIMESTEPS-1:0]       row_ff, row_in;
   logic [TW-1:0]              b_ff, b_in;
   logic                       in_run_ff, in_run_in;
   logic [TW-1:0]              start_ff, start_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   obit_pkg::rsp_type          rsp_ff, rsp_in;

   // memory ports
   logic                 map_we, map_re, list_we, list_re;
   logic [AW-1:0]        map_waddr, map_raddr, list_waddr, list_raddr;
   logic [TIMESTEPS-1:0] map_wdata, list_wdata, map_rdata, list_rdata;

   // derived values
   logic [TW-1:0]        last_eff;
   logic [TIMESTEPS-1:0] tmask;
   logic [TIMESTEPS-1:0] t_onehot;
   logic [TIMESTEPS-1:0] ext_row;
   logic [TW-1:0]        tp1;
   logic                 v_bad, tv_bad, t_bad_mark, t_bad_chk;
   logic                 cpl_more;
   logic                 scan_bit, run_end, rest_zero;

   function automatic obit_pkg::rsp_type make_rsp(
      input obit_pkg::status_type status,
      input logic                 conflict,
      input logic [TW-1:0]        istart,
      input logic [TW-1:0]        iend,
      input logic                 open_end,
      input logic                 last
   );
      obit_pkg::rsp_type r;
      r.status   = status;
      r.conflict = conflict;
      r.istart   = istart;
      r.iend     = iend;
      r.open_end = open_end;
      r.last     = last;
      return r;
   endfunction

   obit_ram #(
      .WIDTH (TIMESTEPS),
      .DEPTH (VERTICES)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_en   (map_re),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   obit_ram #(
      .WIDTH (TIMESTEPS),
      .DEPTH (VERTICES)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (list_we),
      .wr_addr (list_waddr),
      .wr_data (list_wdata),
      .rd_en   (list_re),
      .rd_addr (list_raddr),
      .rd_data (list_rdata)
   );

   always_comb begin
      last_eff = (last_time_ff > TW'(TIMESTEPS - 1)) ? TW'(TIMESTEPS - 1) : last_time_ff;
      for (int i = 0; i < TIMESTEPS; i++) begin
         tmask[i] = (7'(i) <= {1'b0, last_eff});
      end
      t_onehot = {{(TIMESTEPS - 1){1'b0}}, 1'b1} << t_ff[TIB-1:0];
      tp1      = t_ff + TW'(1);
      ext_row  = list_rdata & tmask;

      v_bad      = ({1'b0, req_vertex} >= vertex_count_ff) ||
                   (32'(req_vertex) >= 32'(VERTICES));
      tv_bad     = ({1'b0, req_target_vertex} >= vertex_count_ff) ||
                   (32'(req_target_vertex) >= 32'(VERTICES));
      t_bad_mark = req_time_req > last_eff;
      t_bad_chk  = ({1'b0, req_time_req} + 7'd1) > {1'b0, last_eff};

      cpl_more = (32'(rd_idx_ff) < 32'(vertex_count_ff)) &&
                 (32'(rd_idx_ff) < 32'(VERTICES));

      // the row is masked to last_time, so a run end with all bits above bit 0 zero ends the scan
      scan_bit  = row_ff[0];
      run_end   = scan_bit && !row_ff[1];
      rest_zero = (row_ff[TIMESTEPS-1:1] == '0);
   end

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      v_in         = v_ff;
      tv_in        = tv_ff;
      t_in         = t_ff;
      also_in      = also_ff;
      rd_idx_in    = rd_idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_idx_in  = pend_idx_ff;
      row_in       = row_ff;
      b_in         = b_ff;
      in_run_in    = in_run_ff;
      start_in     = start_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      map_we     = 1'b0;
      map_waddr  = AW'(v_ff);
      map_wdata  = map_rdata | t_onehot;
      map_re     = 1'b0;
      map_raddr  = AW'(req_vertex);
      list_we    = 1'b0;
      list_waddr = AW'(v_ff);
      list_wdata = list_rdata | t_onehot;
      list_re    = 1'b0;
      list_raddr = AW'(req_vertex);

      unique case (state_ff)
         obit_pkg::ST_CLEAR: begin
            map_we     = 1'b1;
            list_we    = 1'b1;
            map_waddr  = clr_idx_ff;
            list_waddr = clr_idx_ff;
            map_wdata  = '0;
            list_wdata = '0;
            clr_idx_in = clr_idx_ff + AW'(1);
            if (clr_idx_ff == AW'(VERTICES - 1)) begin
               state_in = obit_pkg::ST_IDLE;
            end
         end

         obit_pkg::ST_IDLE: begin
            if (start) begin
               v_in    = req_vertex;
               tv_in   = req_target_vertex;
               t_in    = req_time_req;
               also_in = req_also_list;
               unique case (obit_pkg::kind_type'(req_kind))
                  obit_pkg::KIND_MARK: begin
                     priority if (v_bad) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(obit_pkg::STATUS_BAD_VERTEX, 1'b0, '0, '0, 1'b0, 1'b1);
                     end else if (t_bad_mark) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(obit_pkg::STATUS_BAD_TIME, 1'b0, '0, '0, 1'b0, 1'b1);
                     end else begin
                        map_re   = 1'b1;
                        list_re  = 1'b1;
                        state_in = obit_pkg::ST_MARK_WR;
                     end
                  end
                  obit_pkg::KIND_COMPLETE: begin
                     rd_idx_in   = '0;
                     pend_vld_in = 1'b0;
                     state_in    = obit_pkg::ST_CPL;
                  end
                  obit_pkg::KIND_CHECK: begin
                     priority if (v_bad || tv_bad) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(obit_pkg::STATUS_BAD_VERTEX, 1'b0, '0, '0, 1'b0, 1'b1);
                     end else if (t_bad_chk) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(obit_pkg::STATUS_BAD_TIME, 1'b0, '0, '0, 1'b0, 1'b1);
                     end else begin
                        map_re   = 1'b1;
                        state_in = obit_pkg::ST_CHK_SRC;
                     end
                  end
                  obit_pkg::KIND_EXTRACT: begin
                     if (v_bad) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(obit_pkg::STATUS_BAD_VERTEX, 1'b0, '0, '0, 1'b0, 1'b1);
                     end else begin
                        list_re  = 1'b1;
                        state_in = obit_pkg::ST_EXT_LOAD;
                     end
                  end
               endcase
            end
         end

         obit_pkg::ST_MARK_WR: begin
            map_we       = 1'b1;
            list_we      = also_ff;
            rsp_valid_in = 1'b1;
            rsp_in       = make_rsp(obit_pkg::STATUS_OK, 1'b0, '0, '0, 1'b0, 1'b1);
            state_in     = obit_pkg::ST_IDLE;
         end

         obit_pkg::ST_CPL: begin
            // read row i while row i-1 is written back
            if (pend_vld_ff) begin
               list_we    = 1'b1;
               list_waddr = pend_idx_ff;
               list_wdata = list_rdata | (map_rdata & tmask);
            end
            if (cpl_more) begin
               map_re      = 1'b1;
               list_re     = 1'b1;
               map_raddr   = rd_idx_ff[AW-1:0];
               list_raddr  = rd_idx_ff[AW-1:0];
               rd_idx_in   = rd_idx_ff + (AW + 1)'(1);
               pend_vld_in = 1'b1;
               pend_idx_in = rd_idx_ff[AW-1:0];
            end else begin
               pend_vld_in  = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(obit_pkg::STATUS_OK, 1'b0, '0, '0, 1'b0, 1'b1);
               state_in     = obit_pkg::ST_IDLE;
            end
         end

         obit_pkg::ST_CHK_SRC: begin
            if (!map_rdata[t_ff[TIB-1:0]]) begin
               rsp_valid_in = 1'b1;
               rsp_in = make_rsp(obit_pkg::STATUS_SRC_UNSAFE, 1'b0, '0, '0, 1'b0, 1'b1);
               state_in = obit_pkg::ST_IDLE;
            end else begin
               map_re    = 1'b1;
               map_raddr = AW'(tv_ff);
               state_in  = obit_pkg::ST_CHK_DST;
            end
         end

         obit_pkg::ST_CHK_DST: begin
            rsp_valid_in = 1'b1;
            rsp_in = make_rsp(obit_pkg::STATUS_OK, !map_rdata[tp1[TIB-1:0]], '0, '0, 1'b0,
                              1'b1);
            state_in = obit_pkg::ST_IDLE;
         end

         obit_pkg::ST_EXT_LOAD: begin
            if (ext_row == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in = make_rsp(obit_pkg::STATUS_NO_INTERVAL, 1'b0, '0, '0, 1'b0, 1'b1);
               state_in = obit_pkg::ST_IDLE;
            end else begin
               row_in    = ext_row;
               b_in      = '0;
               in_run_in = 1'b0;
               state_in  = obit_pkg::ST_EXT_SCAN;
            end
         end

         obit_pkg::ST_EXT_SCAN: begin
            row_in    = row_ff >> 1;
            b_in      = b_ff + TW'(1);
            in_run_in = scan_bit;
            if (scan_bit && !in_run_ff) begin
               start_in = b_ff;
            end
            if (run_end) begin
               rsp_valid_in = 1'b1;
               rsp_in = make_rsp(obit_pkg::STATUS_OK, 1'b0, in_run_ff ? start_ff : b_ff, b_ff,
                                 b_ff == last_eff, rest_zero);
               if (rest_zero) begin
                  state_in = obit_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = obit_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= obit_pkg::ST_CLEAR;
         clr_idx_ff      <= '0;
         pend_vld_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         last_time_ff    <= obit_pkg::LAST_TIME_RESET;
         vertex_count_ff <= obit_pkg::VERTEX_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               obit_pkg::CSR_LAST_TIME:    last_time_ff    <= csr_wdata[TW-1:0];
               obit_pkg::CSR_VERTEX_COUNT: vertex_count_ff <= csr_wdata[CW-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      tv_ff       <= tv_in;
      t_ff        <= t_in;
      also_ff     <= also_in;
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      row_ff      <= row_in;
      b_ff        <= b_in;
      in_run_ff   <= in_run_in;
      start_ff    <= start_in;
      rsp_ff      <= rsp_in;
   end

   assign busy               = (state_ff != obit_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_conflict       = rsp_ff.conflict;
   assign rsp_interval_start = rsp_ff.istart;
   assign rsp_interval_end   = rsp_ff.iend;
   assign rsp_open_end       = rsp_ff.open_end;
   assign rsp_last           = rsp_ff.last;

endmodule

`default_nettype wire

FILE: hdl/obit_checker.sv
// ----------------------------------------------------------------------------
// obit_checker
// Port-level checks of the interval table core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module obit_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          rsp_valid,
   input wire logic [obit_pkg::STATUS_W-1:0] rsp_status,
   input wire logic                          rsp_conflict,
   input wire logic [obit_pkg::TIME_W-1:0]   rsp_interval_start,
   input wire logic [obit_pkg::TIME_W-1:0]   rsp_interval_end,
   input wire logic                          rsp_open_end,
   input wire logic                          rsp_last
);

   // reset always starts the clearing pass
   a_reset_clears: assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   // an accepted item either keeps the block busy or answers with a final word
   a_accept_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || (rsp_valid && rsp_last)))
      else $error("accepted item neither started nor answered");

   // more words of an extract follow only while the block stays busy
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final word while idle");

   // error and no-interval words carry no run and end the item
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != obit_pkg::STATUS_OK)) |->
         (rsp_last && !rsp_conflict && !rsp_open_end &&
          (rsp_interval_start == '0) && (rsp_interval_end == '0)))
      else $error("error word with payload or not final");

   // a run reaching the horizon is always the final word
   a_open_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_open_end) |-> rsp_last)
      else $error("open-ended run not final");

endmodule

bind occupancy_bitmap_interval_table_core obit_checker u_obit_checker (.*);

`default_nettype wire
